// ===== design/sine_cosine_table_interp_macros.svh =====
// ----------------------------------------------------------------------------
// Sine/cosine table interpolator: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef SINE_COSINE_TABLE_INTERP_MACROS_SVH
`define SINE_COSINE_TABLE_INTERP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sine_cosine_table_interp: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sine_cosine_table_interp: property failed");

`endif

// ===== design/sctbl_pkg.sv =====
// ----------------------------------------------------------------------------
// Sine/cosine table interpolator: package
// Quarter-wave sine table and the types shared by the datapath modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sctbl_pkg;

  localparam int AngleW = 18;
  localparam int ArgW   = 17;
  localparam int MagW   = 17;
  localparam int OutW   = 18;
  localparam int FracW  = 8;
  localparam int IdxW   = ArgW - FracW;

  typedef logic [AngleW-1:0] sctbl_angle_t;
  typedef logic [ArgW-1:0]   sctbl_arg_t;
  typedef logic [MagW-1:0]   sctbl_mag_t;
  typedef logic [IdxW-1:0]   sctbl_idx_t;

  // entries past the table body
  localparam sctbl_mag_t QuarterTop = 17'h10000;
  localparam sctbl_mag_t QuarterEnd = 17'h0FFFE;

  localparam sctbl_mag_t QuarterRom [256] = '{
    17'h0000, 17'h0192, 17'h0324, 17'h04B6, 17'h0648, 17'h07DA, 17'h096C, 17'h0AFE,
    17'h0C8F, 17'h0E21, 17'h0FB2, 17'h1144, 17'h12D5, 17'h1466, 17'h15F6, 17'h1787,
    17'h1917, 17'h1AA7, 17'h1C37, 17'h1DC7, 17'h1F56, 17'h20E5, 17'h2273, 17'h2402,
    17'h2590, 17'h271D, 17'h28AA, 17'h2A37, 17'h2BC4, 17'h2D50, 17'h2EDB, 17'h3066,
    17'h31F1, 17'h337B, 17'h3505, 17'h368E, 17'h3817, 17'h399F, 17'h3B26, 17'h3CAD,
    17'h3E33, 17'h3FB9, 17'h413E, 17'h42C3, 17'h4447, 17'h45CA, 17'h474D, 17'h48CE,
    17'h4A50, 17'h4BD0, 17'h4D50, 17'h4ECF, 17'h504D, 17'h51CA, 17'h5347, 17'h54C3,
    17'h563E, 17'h57B8, 17'h5931, 17'h5AAA, 17'h5C22, 17'h5D98, 17'h5F0E, 17'h6083,
    17'h61F7, 17'h636A, 17'h64DC, 17'h664D, 17'h67BD, 17'h692D, 17'h6A9B, 17'h6C08,
    17'h6D74, 17'h6EDF, 17'h7049, 17'h71B1, 17'h7319, 17'h7480, 17'h75E5, 17'h774A,
    17'h78AD, 17'h7A0F, 17'h7B70, 17'h7CD0, 17'h7E2E, 17'h7F8B, 17'h80E7, 17'h8242,
    17'h839C, 17'h84F4, 17'h864B, 17'h87A1, 17'h88F5, 17'h8A48, 17'h8B9A, 17'h8CEA,
    17'h8E39, 17'h8F87, 17'h90D3, 17'h921E, 17'h9368, 17'h94B0, 17'h95F6, 17'h973C,
    17'h987F, 17'h99C2, 17'h9B02, 17'h9C42, 17'h9D7F, 17'h9EBC, 17'h9FF6, 17'hA12F,
    17'hA267, 17'hA39D, 17'hA4D2, 17'hA605, 17'hA736, 17'hA866, 17'hA994, 17'hAAC0,
    17'hABEB, 17'hAD14, 17'hAE3B, 17'hAF61, 17'hB085, 17'hB1A8, 17'hB2C8, 17'hB3E7,
    17'hB504, 17'hB620, 17'hB73A, 17'hB852, 17'hB968, 17'hBA7C, 17'hBB8F, 17'hBCA0,
    17'hBDAE, 17'hBEBC, 17'hBFC7, 17'hC0D0, 17'hC1D8, 17'hC2DE, 17'hC3E2, 17'hC4E3,
    17'hC5E4, 17'hC6E2, 17'hC7DE, 17'hC8D8, 17'hC9D1, 17'hCAC7, 17'hCBBB, 17'hCCAE,
    17'hCD9F, 17'hCE8D, 17'hCF7A, 17'hD064, 17'hD14D, 17'hD233, 17'hD318, 17'hD3FA,
    17'hD4DB, 17'hD5B9, 17'hD695, 17'hD770, 17'hD848, 17'hD91E, 17'hD9F2, 17'hDAC4,
    17'hDB94, 17'hDC61, 17'hDD2D, 17'hDDF6, 17'hDEBE, 17'hDF83, 17'hE046, 17'hE106,
    17'hE1C5, 17'hE282, 17'hE33C, 17'hE3F4, 17'hE4AA, 17'hE55E, 17'hE60F, 17'hE6BE,
    17'hE76B, 17'hE816, 17'hE8BF, 17'hE965, 17'hEA09, 17'hEAAB, 17'hEB4B, 17'hEBE8,
    17'hEC83, 17'hED1C, 17'hEDB2, 17'hEE46, 17'hEED8, 17'hEF68, 17'hEFF5, 17'hF080,
    17'hF109, 17'hF18F, 17'hF213, 17'hF294, 17'hF314, 17'hF391, 17'hF40B, 17'hF484,
    17'hF4FA, 17'hF56D, 17'hF5DE, 17'hF64D, 17'hF6BA, 17'hF724, 17'hF78B, 17'hF7F1,
    17'hF853, 17'hF8B4, 17'hF912, 17'hF96E, 17'hF9C7, 17'hFA1E, 17'hFA73, 17'hFAC5,
    17'hFB14, 17'hFB61, 17'hFBAC, 17'hFBF5, 17'hFC3B, 17'hFC7E, 17'hFCBF, 17'hFCFE,
    17'hFD3A, 17'hFD74, 17'hFDAB, 17'hFDE0, 17'hFE13, 17'hFE43, 17'hFE70, 17'hFE9B,
    17'hFEC4, 17'hFEEA, 17'hFF0E, 17'hFF2F, 17'hFF4E, 17'hFF6A, 17'hFF84, 17'hFF9C,
    17'hFFB1, 17'hFFC3, 17'hFFD3, 17'hFFE1, 17'hFFEC, 17'hFFF4, 17'hFFFB, 17'hFFFE
  };

  // Table entry 0..257; the two entries past the body sit outside the array.
  function automatic sctbl_mag_t sctbl_rom_entry(input sctbl_idx_t idx);
    sctbl_mag_t val;
    if (idx[IdxW-1]) begin
      val = idx[0] ? QuarterEnd : QuarterTop;
    end else begin
      val = QuarterRom[idx[IdxW-2:0]];
    end
    return val;
  endfunction

endpackage

// ===== design/sine_cosine_table_interp.sv =====
// ----------------------------------------------------------------------------
// Sine/cosine table interpolator
// Cosine and sine of an 18-bit angle in signed Q2.16, by quarter-wave table.
// ----------------------------------------------------------------------------
// Usage:
//   Drive angle_i (a full turn is 2^18) and raise start_i; the beat is taken
//   at any rising edge with start_i high and busy_o low. busy_o is tied low,
//   so one beat may be issued every cycle.
//   The angle lands in the input register at the accepting edge; folding,
//   table reads and interpolation run in the cycle after, and the result
//   register presents cosine_o and sine_o with valid_o high for exactly
//   one cycle following that.
//   Throughput is one result per cycle, set by the single pass through two
//   interpolators (one multiplier each) between the two registers.
//   The receiver cannot stall: each result is shown once and is gone in the
//   next cycle. Reset clears the valid flags, dropping any beat in flight;
//   the angle and result registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_cosine_table_interp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [17:0]             angle_i,
  output logic                    busy_o,
  output logic                    valid_o,
  output logic signed [17:0]      cosine_o,
  output logic signed [17:0]      sine_o
);
  import sctbl_pkg::*;

  logic                   accept;
  logic                   in_vld_q;
  sctbl_angle_t           angle_q;
  logic                   out_vld_q;
  logic signed [OutW-1:0] cos_q, cos_d;
  logic signed [OutW-1:0] sin_q, sin_d;

  logic [ArgW-2:0] low;
  sctbl_arg_t      comp;
  sctbl_arg_t      cos_arg;
  sctbl_arg_t      sin_arg;
  sctbl_mag_t      cos_mag;
  sctbl_mag_t      sin_mag;
  logic            neg_cos;
  logic            neg_sin;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      angle_q <= angle_i;
    end
    if (in_vld_q) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  // Fold to a quarter wave: each argument is either the offset into the
  // quarter or its complement to a quarter turn.
  assign low     = angle_q[ArgW-2:0];
  assign comp    = QuarterTop - {1'b0, low};
  assign cos_arg = angle_q[ArgW-1] ? {1'b0, low} : comp;
  assign sin_arg = angle_q[ArgW-1] ? comp : {1'b0, low};
  assign neg_cos = angle_q[ArgW-1] ^ angle_q[AngleW-1];
  assign neg_sin = angle_q[AngleW-1];

  sctbl_quarter u_cos (
    .arg_i (cos_arg),
    .mag_o (cos_mag)
  );

  sctbl_quarter u_sin (
    .arg_i (sin_arg),
    .mag_o (sin_mag)
  );

  always_comb begin
    cos_d = $signed({1'b0, cos_mag});
    sin_d = $signed({1'b0, sin_mag});
    if (neg_cos) begin
      cos_d = -$signed({1'b0, cos_mag});
    end
    if (neg_sin) begin
      sin_d = -$signed({1'b0, sin_mag});
    end
  end

  assign valid_o  = out_vld_q;
  assign cosine_o = cos_q;
  assign sine_o   = sin_q;

endmodule

// ===== design/sctbl_quarter.sv =====
// ----------------------------------------------------------------------------
// Sine/cosine table interpolator: quarter-wave sine
// Reads two neighbouring table entries and interpolates by the low bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sctbl_quarter (
  input  sctbl_pkg::sctbl_arg_t arg_i,
  output sctbl_pkg::sctbl_mag_t mag_o
);
  import sctbl_pkg::*;

  sctbl_idx_t         idx;
  logic [FracW-1:0]   frac;
  sctbl_mag_t         s0;
  sctbl_mag_t         s1;
  logic signed [MagW:0]              diff;
  logic signed [MagW+FracW+1:0]      prod;
  logic signed [MagW+1:0]            step;
  logic signed [MagW+1:0]            sum;

  assign idx  = arg_i[ArgW-1:FracW];
  assign frac = arg_i[FracW-1:0];
  assign s0   = sctbl_rom_entry(idx);
  assign s1   = sctbl_rom_entry(idx + IdxW'(1));

  assign diff = $signed({1'b0, s1}) - $signed({1'b0, s0});
  assign prod = (MagW+FracW+2)'(diff) * (MagW+FracW+2)'($signed({1'b0, frac}));
  // arithmetic shift: floor of the scaled slope
  assign step = prod[MagW+FracW+1:FracW];
  assign sum  = $signed({2'b00, s0}) + step;
  assign mag_o = sum[MagW-1:0];

endmodule

// ===== design/sctbl_checker.sv =====
// ----------------------------------------------------------------------------
// Sine/cosine table interpolator: port checker
// Timing and range properties seen on the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sine_cosine_table_interp_macros.svh"

module sctbl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic [17:0]        angle_i,
  input logic               busy_o,
  input logic               valid_o,
  input logic signed [17:0] cosine_o,
  input logic signed [17:0] sine_o
);

  `SCT_ASSERT_NOW(never_busy, clk_i, rst_ni, 1'b1, !busy_o)

  // every beat taken comes out on valid_o after the input and result registers
  `SCT_ASSERT_NEXT(beat_returns, clk_i, rst_ni, start_i && !busy_o, ##1 valid_o)

  // no result without a beat taken ahead of it through the input and result registers
  `SCT_ASSERT_NOW(no_spurious, clk_i, rst_ni, valid_o, $past(start_i && !busy_o, 2))

  `SCT_ASSERT_NOW(unit_range, clk_i, rst_ni, valid_o,
    (cosine_o >= -18'sd65536) && (cosine_o <= 18'sd65536) &&
    (sine_o >= -18'sd65536) && (sine_o <= 18'sd65536))

  // zero angle gives exactly one and zero
  `SCT_ASSERT_NOW(zero_angle, clk_i, rst_ni,
    valid_o && ($past(angle_i, 2) == 18'd0),
    (cosine_o == 18'sd65536) && (sine_o == 18'sd0))

endmodule

bind sine_cosine_table_interp sctbl_checker u_sctbl_checker (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Sine/cosine table interpolator: testbench
// Sends angles into the block and compares each cosine/sine beat against
// its own quarter-wave table model. Directed corner angles run first, then
// random ones. The sender leaves idle gaps at two densities, then none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import sctbl_pkg::*;

  localparam int Quarter    = 'h10000;
  localparam int HalfTurn   = 'h20000;
  localparam int RandBeats  = 1150;
  localparam int TailCycles = 8;
  localparam int CycleLimit = 200000;

  // Quarter-sine table, 256 body entries plus the two past the top.
  localparam int SineQuarter [258] = '{
    'h0000, 'h0192, 'h0324, 'h04B6, 'h0648, 'h07DA, 'h096C, 'h0AFE,
    'h0C8F, 'h0E21, 'h0FB2, 'h1144, 'h12D5, 'h1466, 'h15F6, 'h1787,
    'h1917, 'h1AA7, 'h1C37, 'h1DC7, 'h1F56, 'h20E5, 'h2273, 'h2402,
    'h2590, 'h271D, 'h28AA, 'h2A37, 'h2BC4, 'h2D50, 'h2EDB, 'h3066,
    'h31F1, 'h337B, 'h3505, 'h368E, 'h3817, 'h399F, 'h3B26, 'h3CAD,
    'h3E33, 'h3FB9, 'h413E, 'h42C3, 'h4447, 'h45CA, 'h474D, 'h48CE,
    'h4A50, 'h4BD0, 'h4D50, 'h4ECF, 'h504D, 'h51CA, 'h5347, 'h54C3,
    'h563E, 'h57B8, 'h5931, 'h5AAA, 'h5C22, 'h5D98, 'h5F0E, 'h6083,
    'h61F7, 'h636A, 'h64DC, 'h664D, 'h67BD, 'h692D, 'h6A9B, 'h6C08,
    'h6D74, 'h6EDF, 'h7049, 'h71B1, 'h7319, 'h7480, 'h75E5, 'h774A,
    'h78AD, 'h7A0F, 'h7B70, 'h7CD0, 'h7E2E, 'h7F8B, 'h80E7, 'h8242,
    'h839C, 'h84F4, 'h864B, 'h87A1, 'h88F5, 'h8A48, 'h8B9A, 'h8CEA,
    'h8E39, 'h8F87, 'h90D3, 'h921E, 'h9368, 'h94B0, 'h95F6, 'h973C,
    'h987F, 'h99C2, 'h9B02, 'h9C42, 'h9D7F, 'h9EBC, 'h9FF6, 'hA12F,
    'hA267, 'hA39D, 'hA4D2, 'hA605, 'hA736, 'hA866, 'hA994, 'hAAC0,
    'hABEB, 'hAD14, 'hAE3B, 'hAF61, 'hB085, 'hB1A8, 'hB2C8, 'hB3E7,
    'hB504, 'hB620, 'hB73A, 'hB852, 'hB968, 'hBA7C, 'hBB8F, 'hBCA0,
    'hBDAE, 'hBEBC, 'hBFC7, 'hC0D0, 'hC1D8, 'hC2DE, 'hC3E2, 'hC4E3,
    'hC5E4, 'hC6E2, 'hC7DE, 'hC8D8, 'hC9D1, 'hCAC7, 'hCBBB, 'hCCAE,
    'hCD9F, 'hCE8D, 'hCF7A, 'hD064, 'hD14D, 'hD233, 'hD318, 'hD3FA,
    'hD4DB, 'hD5B9, 'hD695, 'hD770, 'hD848, 'hD91E, 'hD9F2, 'hDAC4,
    'hDB94, 'hDC61, 'hDD2D, 'hDDF6, 'hDEBE, 'hDF83, 'hE046, 'hE106,
    'hE1C5, 'hE282, 'hE33C, 'hE3F4, 'hE4AA, 'hE55E, 'hE60F, 'hE6BE,
    'hE76B, 'hE816, 'hE8BF, 'hE965, 'hEA09, 'hEAAB, 'hEB4B, 'hEBE8,
    'hEC83, 'hED1C, 'hEDB2, 'hEE46, 'hEED8, 'hEF68, 'hEFF5, 'hF080,
    'hF109, 'hF18F, 'hF213, 'hF294, 'hF314, 'hF391, 'hF40B, 'hF484,
    'hF4FA, 'hF56D, 'hF5DE, 'hF64D, 'hF6BA, 'hF724, 'hF78B, 'hF7F1,
    'hF853, 'hF8B4, 'hF912, 'hF96E, 'hF9C7, 'hFA1E, 'hFA73, 'hFAC5,
    'hFB14, 'hFB61, 'hFBAC, 'hFBF5, 'hFC3B, 'hFC7E, 'hFCBF, 'hFCFE,
    'hFD3A, 'hFD74, 'hFDAB, 'hFDE0, 'hFE13, 'hFE43, 'hFE70, 'hFE9B,
    'hFEC4, 'hFEEA, 'hFF0E, 'hFF2F, 'hFF4E, 'hFF6A, 'hFF84, 'hFF9C,
    'hFFB1, 'hFFC3, 'hFFD3, 'hFFE1, 'hFFEC, 'hFFF4, 'hFFFB, 'hFFFE,
    'h10000, 'hFFFE
  };

  typedef struct {
    sctbl_angle_t ang;
    int unsigned  gap_pct;
  } angle_beat_t;

  typedef struct {
    logic signed [17:0] cosine;
    logic signed [17:0] sine;
  } trig_pair_t;

  logic               clk_i   = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start_i = 1'b0;
  sctbl_angle_t       angle_i = '0;
  logic               busy_o;
  logic               valid_o;
  logic signed [17:0] cosine_o;
  logic signed [17:0] sine_o;

  angle_beat_t angle_backlog [$];
  trig_pair_t  trig_due [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  sine_cosine_table_interp i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_n),
    .start_i  (start_i),
    .angle_i  (angle_i),
    .busy_o   (busy_o),
    .valid_o  (valid_o),
    .cosine_o (cosine_o),
    .sine_o   (sine_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Interpolated quarter sine for a folded angle in [0, pi/2].
  function automatic int interp_quarter(input int a);
    int idx;
    int frac;
    int lo;
    int hi;
    idx  = (a >> 8) & 'h1FF;
    frac = a & 'hFF;
    if (idx > 256) begin
      idx = 256;
    end
    lo = SineQuarter[idx];
    hi = SineQuarter[idx + 1];
    // arithmetic shift floors a negative slope
    return lo + (((hi - lo) * frac) >>> 8);
  endfunction

  function automatic trig_pair_t predict_trig(input sctbl_angle_t ang);
    int         m;
    int         c;
    int         s;
    trig_pair_t r;
    m = int'(ang[16:0]);
    if (m >= Quarter) begin
      c = -interp_quarter(m - Quarter);
      s = interp_quarter(HalfTurn - m);
    end else begin
      c = interp_quarter(Quarter - m);
      s = interp_quarter(m);
    end
    if (ang[17]) begin
      c = -c;
      s = -s;
    end
    r.cosine = c[17:0];
    r.sine   = s[17:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic queue_angle(input int unsigned ang, input int unsigned gap_pct);
    angle_beat_t b;
    b.ang     = ang[17:0];
    b.gap_pct = gap_pct;
    angle_backlog.push_back(b);
  endtask

  // Driver: record the beat taken at this edge, then present the next one.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      start_i <= 1'b0;
      angle_i <= '0;
    end else begin : drive
      angle_beat_t nxt;
      if (start_i && !busy_o) begin
        trig_due.push_back(predict_trig(angle_i));
      end
      // hold a beat that was not taken
      if (!start_i || !busy_o) begin
        if (angle_backlog.size() > 0 &&
            $urandom_range(99) >= angle_backlog[0].gap_pct) begin
          nxt = angle_backlog.pop_front();
          start_i <= 1'b1;
          angle_i <= nxt.ang;
        end else begin
          start_i <= 1'b0;
          angle_i <= sctbl_angle_t'($urandom_range(18'h3FFFF, 0));
        end
      end
    end
  end

  // Monitor: every strobed beat must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_n && valid_o) begin : check
      trig_pair_t exp_pair;
      if (trig_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat cos=%0d sin=%0d", cosine_o, sine_o));
      end else begin
        exp_pair = trig_due.pop_front();
        if (cosine_o !== exp_pair.cosine) begin
          report_mismatch($sformatf("cosine got %0d want %0d", cosine_o, exp_pair.cosine));
        end
        if (sine_o !== exp_pair.sine) begin
          report_mismatch($sformatf("sine got %0d want %0d", sine_o, exp_pair.sine));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL sine_cosine_table_interp");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned corner [$];
    int unsigned gap;
    int unsigned ang;
    corner = '{
      'h00000, 'h00001, 'h000FF, 'h00100, 'h00180, 'h0FF00, 'h0FFFF, 'h10000,
      'h10001, 'h100FF, 'h18000, 'h1FFFF, 'h20000, 'h20001, 'h2FFFF, 'h30000,
      'h30001, 'h3FF00, 'h3FFFE, 'h3FFFF, 'h08000, 'h28000, 'h2AAAA, 'h15555
    };
    foreach (corner[k]) begin
      queue_angle(corner[k], 31);
    end
    for (int n = 0; n < RandBeats; n++) begin
      gap = (n < RandBeats / 3) ? 31 : (n < 2 * RandBeats / 3) ? 76 : 0;
      if ($urandom_range(9) < 2) begin
        // land close to a quadrant edge, either side
        ang = $urandom_range(3) * Quarter + $urandom_range(600) - 300;
      end else begin
        ang = $urandom;
      end
      queue_angle(ang & 'h3FFFF, gap);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    while (angle_backlog.size() != 0 || start_i) @(posedge clk_i);
    while (trig_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (trig_due.size() != 0) begin
      report_mismatch($sformatf("%0d beats never arrived", trig_due.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("PASS sine_cosine_table_interp");
    end else begin
      $display("FAIL sine_cosine_table_interp");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sctbl_pkg.sv
design/sctbl_quarter.sv
design/sine_cosine_table_interp.sv
design/sctbl_checker.sv
sim/tb_top.sv
